>>> hw/rtl/sfp_pkg.sv
`default_nettype none
package sfp_pkg;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN,
      S_EVAL,
      S_CRD,
      S_CEV,
      S_TRD,
      S_TEV,
      S_ERD,
      S_EEV,
      S_EMIT,
      S_STAT
   } state_type;

   typedef enum logic [0:0] {
      CMD_FEED  = 1'b0,
      CMD_CLEAR = 1'b1
   } cmd_type;

   typedef enum logic [0:0] {
      KIND_CHUNK  = 1'b0,
      KIND_STATUS = 1'b1
   } kind_type;

   localparam logic [7:0]  SYNC0       = 8'hAA;
   localparam logic [7:0]  SYNC1       = 8'h55;
   localparam logic [7:0]  VERSION     = 8'd3;
   localparam logic [7:0]  BAD_BYTE4   = 8'hFF;
   localparam logic [7:0]  FRAME_OVER  = 8'd15;
   localparam logic [15:0] CRC_INIT    = 16'hFFFF;
   localparam logic [15:0] CRC_POLY    = 16'h1021;
   localparam logic [5:0]  MAX_CHUNKS  = 6'd39;
   localparam int          DATA_BITS   = 208;

   localparam logic [2:0] CHK_SYNC0 = 3'd0;
   localparam logic [2:0] CHK_SYNC1 = 3'd1;
   localparam logic [2:0] CHK_VER   = 3'd2;
   localparam logic [2:0] CHK_B4    = 3'd3;
   localparam logic [2:0] CHK_LENLO = 3'd4;
   localparam logic [2:0] CHK_LENHI = 3'd5;

   function automatic logic [7:0] chk_offset(input logic [2:0] chk);
      logic [7:0] o;
      unique case (chk)
         CHK_SYNC0: o = 8'd0;
         CHK_SYNC1: o = 8'd1;
         CHK_VER:   o = 8'd2;
         CHK_B4:    o = 8'd4;
         CHK_LENLO: o = 8'd11;
         CHK_LENHI: o = 8'd12;
         default:   o = 8'd0;
      endcase
      return o;
   endfunction

   function automatic logic [15:0] crc_byte(input logic [15:0] crc_i, input logic [7:0] b);
      logic [15:0] c;
      c = crc_i ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) c = {c[14:0], 1'b0} ^ CRC_POLY;
         else       c = {c[14:0], 1'b0};
      end
      return c;
   endfunction

endpackage
`default_nettype wire

>>> hw/rtl/sfp_ram.sv
`default_nettype none
module sfp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

>>> hw/rtl/sync_frame_parser_crc16_core.sv
// channel  dir  tdata                                            tuser     tlast
// req      in   rx_byte[7:0]                                     command   -
// rsp      out  chunk_data, chunk_bytes, frame_length, counters  kind      frame_last
//
// One item at a time. Each header check, and each byte of the CRC pass, of the trailer
// and of the chunk readout, goes through a read state and an evaluate state, all through
// one store read port. A CRC drop comes only after the frame's CRC pass. Reset clears pointers,
// fill and counters; no clearing pass. A stalled rsp holds the sequencer; req is taken
// again once the status word is loaded.
`default_nettype none
module sync_frame_parser_crc16_core #(
   parameter int STORE_BYTES = 256,
   parameter int MAX_PAYLOAD = 185
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,   // rx_byte[7:0]
   input  wire logic         req_tuser,   // command
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // chunk_data[63:0] chunk_bytes[67:64] frame_length[75:68] sync_drops[107:76]
   // header_drops[139:108] crc_drops[171:140] good_frames[203:172] zero[207:204]
   output logic [sfp_pkg::DATA_BITS-1:0] rsp_tdata,
   output logic              rsp_tuser,   // kind
   output logic              rsp_tlast    // frame_last
);

   localparam int AW = $clog2(STORE_BYTES);
   localparam int CW = $clog2(STORE_BYTES + 1);

   sfp_pkg::state_type state_ff, state_in;

   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [2:0]    chk_ff, chk_in;
   logic [7:0]    off_ff, off_in;
   logic [7:0]    total_ff, total_in;
   logic          b4bad_ff, b4bad_in;
   logic [7:0]    lenlo_ff, lenlo_in;
   logic [15:0]   crc_ff, crc_in;
   logic [7:0]    crclo_ff, crclo_in;
   logic [7:0]    lane_ff [8];
   logic [7:0]    lane_in [8];
   logic [3:0]    cnt_ff, cnt_in;
   logic [5:0]    nchunk_ff, nchunk_in;
   logic [31:0]   sync_ff, sync_in, hdr_ff, hdr_in, crcd_ff, crcd_in, good_ff, good_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [sfp_pkg::DATA_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic                        rsp_kind_ff, rsp_kind_in;
   logic                        rsp_last_ff, rsp_last_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [7:0]    rd_data, rd_off;
   logic          slot_free, accept;
   logic [15:0]   payload;
   logic [7:0]    total_w;
   logic [63:0]   chunk_w;

   sfp_ram #(.WIDTH(8), .DEPTH(2 ** AW)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_tdata),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_tready = (state_ff == sfp_pkg::S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign wr_en      = accept && (req_tuser == sfp_pkg::CMD_FEED)
                       && (fill_ff < CW'(STORE_BYTES));
   assign wr_addr    = head_ff + fill_ff[AW-1:0];
   assign rd_off     = (state_ff == sfp_pkg::S_SCAN) ? sfp_pkg::chk_offset(chk_ff) : off_ff;
   assign rd_addr    = head_ff + AW'(rd_off);
   assign payload    = {rd_data, lenlo_ff};
   assign total_w    = payload[7:0] + sfp_pkg::FRAME_OVER;

   always_comb begin
      for (int k = 0; k < 8; k++) chunk_w[k*8 +: 8] = lane_ff[k];
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sfp_pkg::S_IDLE: begin
            if (accept) state_in = (req_tuser == sfp_pkg::CMD_CLEAR) ? sfp_pkg::S_STAT
                                                                    : sfp_pkg::S_SCAN;
         end
         sfp_pkg::S_SCAN: begin
            state_in = (fill_ff == '0) ? sfp_pkg::S_STAT : sfp_pkg::S_EVAL;
         end
         sfp_pkg::S_EVAL: begin
            state_in = sfp_pkg::S_SCAN;
            unique case (chk_ff)
               sfp_pkg::CHK_SYNC0: if (rd_data == sfp_pkg::SYNC0 && fill_ff < CW'(2))
                  state_in = sfp_pkg::S_STAT;
               sfp_pkg::CHK_SYNC1: if (rd_data == sfp_pkg::SYNC1 && fill_ff < CW'(3))
                  state_in = sfp_pkg::S_STAT;
               sfp_pkg::CHK_VER: if (rd_data == sfp_pkg::VERSION && fill_ff < CW'(13))
                  state_in = sfp_pkg::S_STAT;
               sfp_pkg::CHK_LENHI: begin
                  if (!(payload > 16'(MAX_PAYLOAD) || b4bad_ff)) begin
                     if (fill_ff < CW'(total_w)) state_in = sfp_pkg::S_STAT;
                     else                        state_in = sfp_pkg::S_CRD;
                  end
               end
               default: state_in = sfp_pkg::S_SCAN;
            endcase
         end
         sfp_pkg::S_CRD: state_in = sfp_pkg::S_CEV;
         sfp_pkg::S_CEV: state_in = (off_ff + 8'd1 == total_ff - 8'd2) ? sfp_pkg::S_TRD
                                                                       : sfp_pkg::S_CRD;
         sfp_pkg::S_TRD: state_in = sfp_pkg::S_TEV;
         sfp_pkg::S_TEV: begin
            if (off_ff == total_ff - 8'd2) state_in = sfp_pkg::S_TRD;
            else if ({rd_data, crclo_ff} == crc_ff) state_in = sfp_pkg::S_ERD;
            else state_in = sfp_pkg::S_SCAN;
         end
         sfp_pkg::S_ERD: state_in = sfp_pkg::S_EEV;
         sfp_pkg::S_EEV: state_in = (cnt_ff == 4'd7 || off_ff + 8'd1 == total_ff)
                                    ? sfp_pkg::S_EMIT : sfp_pkg::S_ERD;
         sfp_pkg::S_EMIT: begin
            if (slot_free) state_in = (off_ff == total_ff) ? sfp_pkg::S_SCAN : sfp_pkg::S_ERD;
         end
         sfp_pkg::S_STAT: if (slot_free) state_in = sfp_pkg::S_IDLE;
         default: state_in = sfp_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      head_in   = head_ff;
      fill_in   = fill_ff;
      chk_in    = chk_ff;
      off_in    = off_ff;
      total_in  = total_ff;
      b4bad_in  = b4bad_ff;
      lenlo_in  = lenlo_ff;
      crc_in    = crc_ff;
      crclo_in  = crclo_ff;
      lane_in   = lane_ff;
      cnt_in    = cnt_ff;
      nchunk_in = nchunk_ff;
      sync_in   = sync_ff;
      hdr_in    = hdr_ff;
      crcd_in   = crcd_ff;
      good_in   = good_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         sfp_pkg::S_IDLE: begin
            if (accept) begin
               chk_in    = sfp_pkg::CHK_SYNC0;
               nchunk_in = '0;
               if (req_tuser == sfp_pkg::CMD_CLEAR) fill_in = '0;
               else if (wr_en) fill_in = fill_ff + CW'(1);
            end
         end
         sfp_pkg::S_EVAL: begin
            chk_in = chk_ff + 3'd1;
            unique case (chk_ff)
               sfp_pkg::CHK_SYNC0: if (rd_data != sfp_pkg::SYNC0) begin
                  sync_in = sync_ff + 32'd1;
                  head_in = head_ff + AW'(1);
                  fill_in = fill_ff - CW'(1);
                  chk_in  = sfp_pkg::CHK_SYNC0;
               end
               sfp_pkg::CHK_SYNC1: if (rd_data != sfp_pkg::SYNC1) begin
                  sync_in = sync_ff + 32'd1;
                  head_in = head_ff + AW'(1);
                  fill_in = fill_ff - CW'(1);
                  chk_in  = sfp_pkg::CHK_SYNC0;
               end
               sfp_pkg::CHK_VER: if (rd_data != sfp_pkg::VERSION) begin
                  hdr_in  = hdr_ff + 32'd1;
                  head_in = head_ff + AW'(1);
                  fill_in = fill_ff - CW'(1);
                  chk_in  = sfp_pkg::CHK_SYNC0;
               end
               sfp_pkg::CHK_B4:    b4bad_in = (rd_data == sfp_pkg::BAD_BYTE4);
               sfp_pkg::CHK_LENLO: lenlo_in = rd_data;
               sfp_pkg::CHK_LENHI: begin
                  chk_in   = sfp_pkg::CHK_SYNC0;
                  total_in = total_w;
                  off_in   = '0;
                  crc_in   = sfp_pkg::CRC_INIT;
                  if (payload > 16'(MAX_PAYLOAD) || b4bad_ff) begin
                     hdr_in  = hdr_ff + 32'd1;
                     head_in = head_ff + AW'(1);
                     fill_in = fill_ff - CW'(1);
                  end
               end
               default: chk_in = sfp_pkg::CHK_SYNC0;
            endcase
         end
         sfp_pkg::S_CEV: begin
            crc_in = sfp_pkg::crc_byte(crc_ff, rd_data);
            off_in = off_ff + 8'd1;
         end
         sfp_pkg::S_TEV: begin
            if (off_ff == total_ff - 8'd2) begin
               crclo_in = rd_data;
               off_in   = off_ff + 8'd1;
            end else if ({rd_data, crclo_ff} == crc_ff) begin
               good_in = good_ff + 32'd1;
               off_in  = '0;
               cnt_in  = '0;
               for (int k = 0; k < 8; k++) lane_in[k] = '0;
            end else begin
               crcd_in = crcd_ff + 32'd1;
               head_in = head_ff + AW'(1);
               fill_in = fill_ff - CW'(1);
            end
         end
         sfp_pkg::S_EEV: begin
            lane_in[cnt_ff[2:0]] = rd_data;
            cnt_in = cnt_ff + 4'd1;
            off_in = off_ff + 8'd1;
         end
         sfp_pkg::S_EMIT: begin
            if (slot_free) begin
               if (nchunk_ff < sfp_pkg::MAX_CHUNKS) begin
                  nchunk_in    = nchunk_ff + 6'd1;
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = sfp_pkg::KIND_CHUNK;
                  rsp_last_in  = (off_ff == total_ff);
                  rsp_data_in  = {132'd0, total_ff, cnt_ff, chunk_w};
               end
               cnt_in = '0;
               for (int k = 0; k < 8; k++) lane_in[k] = '0;
               if (off_ff == total_ff) begin
                  head_in = head_ff + AW'(total_ff);
                  fill_in = fill_ff - CW'(total_ff);
               end
            end
         end
         sfp_pkg::S_STAT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = sfp_pkg::KIND_STATUS;
               rsp_last_in  = 1'b0;
               rsp_data_in  = {4'd0, good_ff, crcd_ff, hdr_ff, sync_ff, 8'd0, 4'd0, 64'd0};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sfp_pkg::S_IDLE;
         head_ff      <= '0;
         fill_ff      <= '0;
         chk_ff       <= sfp_pkg::CHK_SYNC0;
         cnt_ff       <= '0;
         nchunk_ff    <= '0;
         sync_ff      <= '0;
         hdr_ff       <= '0;
         crcd_ff      <= '0;
         good_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         chk_ff       <= chk_in;
         cnt_ff       <= cnt_in;
         nchunk_ff    <= nchunk_in;
         sync_ff      <= sync_in;
         hdr_ff       <= hdr_in;
         crcd_ff      <= crcd_in;
         good_ff      <= good_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      off_ff      <= off_in;
      total_ff    <= total_in;
      b4bad_ff    <= b4bad_in;
      lenlo_ff    <= lenlo_in;
      crc_ff      <= crc_in;
      crclo_ff    <= crclo_in;
      lane_ff     <= lane_in;
      rsp_data_ff <= rsp_data_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(STORE_BYTES))
      else $error("fill above store size");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second item taken before status");

   a_chunk_size: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[67:64] != 4'd0 && rsp_tdata[67:64] <= 4'd8)
      else $error("chunk byte count out of range");

   a_status_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == sfp_pkg::S_STAT && slot_free |=> req_tready && rsp_tvalid && rsp_tuser)
      else $error("status not loaded");

endmodule
`default_nettype wire

>>> test/tb.sv
`timescale 1ns / 1ps
module tb;

   typedef logic [7:0] byte_q_type[$];

   typedef struct packed {
      logic         kind;
      logic         last;
      logic [207:0] word;
   } rsp_word_type;

   typedef struct {
      sfp_pkg::cmd_type cmd;
      logic [7:0]  data;
      bit          typed;
      logic [31:0] n_sync;
      logic [31:0] n_hdr;
      logic [31:0] n_crc;
      logic [31:0] n_good;
   } stim_row_type;

   localparam int WATCHDOG_LIMIT = 20000;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [7:0]   req_tdata;
   logic         req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [sfp_pkg::DATA_BITS-1:0] rsp_tdata;
   logic         rsp_tuser;
   logic         rsp_tlast;

   logic [7:0]   rx_bytes[$];
   logic [31:0]  sync_drops, header_drops, crc_drops, good_frames;
   rsp_word_type pending_words[$];
   stim_row_type directed_rows[$];
   int           mismatches;
   int           words_checked;
   int           bytes_fed;
   int           sender_idle;
   int           recv_idle;
   int           stall_cycles;

   sync_frame_parser_crc16_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   function automatic logic [15:0] frame_crc(input byte_q_type q, input int len);
      logic [15:0] c;
      c = 16'hFFFF;
      for (int i = 0; i < len; i++) begin
         c = c ^ {q[i], 8'h00};
         for (int k = 0; k < 8; k++)
            c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

   function automatic rsp_word_type status_word();
      rsp_word_type w;
      w.kind = sfp_pkg::KIND_STATUS;
      w.last = 1'b0;
      w.word = {4'b0, good_frames, crc_drops, header_drops, sync_drops, 8'd0, 4'd0, 64'd0};
      return w;
   endfunction

   task automatic parse_item(input sfp_pkg::cmd_type cmd, input logic [7:0] data);
      int plen, total, cnt, nch;
      logic [63:0] d;
      rsp_word_type w;
      nch = 0;
      if (cmd == sfp_pkg::CMD_CLEAR) begin
         rx_bytes.delete();
      end else begin
         if (rx_bytes.size() < 256) rx_bytes.push_back(data);
         while (rx_bytes.size() != 0) begin
            if (rx_bytes[0] != sfp_pkg::SYNC0 ||
                (rx_bytes.size() >= 2 && rx_bytes[1] != sfp_pkg::SYNC1)) begin
               sync_drops++;
               void'(rx_bytes.pop_front());
               continue;
            end
            if (rx_bytes.size() < 3) break;
            if (rx_bytes[2] != sfp_pkg::VERSION) begin
               header_drops++;
               void'(rx_bytes.pop_front());
               continue;
            end
            if (rx_bytes.size() < 13) break;
            plen = {rx_bytes[12], rx_bytes[11]};
            if (plen > 185 || rx_bytes[4] == sfp_pkg::BAD_BYTE4) begin
               header_drops++;
               void'(rx_bytes.pop_front());
               continue;
            end
            total = 15 + plen;
            if (rx_bytes.size() < total) break;
            if (frame_crc(rx_bytes, total - 2) != {rx_bytes[total-1], rx_bytes[total-2]}) begin
               crc_drops++;
               void'(rx_bytes.pop_front());
               continue;
            end
            good_frames++;
            for (int pos = 0; pos < total; pos += 8) begin
               cnt = (total - pos > 8) ? 8 : total - pos;
               if (nch >= 39) break;
               d = '0;
               for (int k = 0; k < cnt; k++) d[8*k +: 8] = rx_bytes[pos+k];
               w.kind = sfp_pkg::KIND_CHUNK;
               w.last = (pos + cnt >= total);
               w.word = {132'd0, total[7:0], cnt[3:0], d};
               pending_words.push_back(w);
               nch++;
            end
            repeat (total) void'(rx_bytes.pop_front());
         end
      end
      pending_words.push_back(status_word());
   endtask

   function automatic byte_q_type build_frame(input int plen, input int flaw);
      byte_q_type q;
      logic [15:0] c;
      int i;
      q.push_back(sfp_pkg::SYNC0);
      q.push_back(sfp_pkg::SYNC1);
      q.push_back(sfp_pkg::VERSION);
      for (i = 3; i < 11; i++) q.push_back(8'($urandom_range(0, 255)));
      if (q[4] == sfp_pkg::BAD_BYTE4) q[4] = 8'hFE;
      q.push_back(plen[7:0]);
      q.push_back(plen[15:8]);
      for (i = 0; i < plen; i++) q.push_back(8'($urandom_range(0, 255)));
      case (flaw)
         1: q[2] = q[2] ^ (8'd1 << $urandom_range(0, 7));
         2: q[4] = sfp_pkg::BAD_BYTE4;
         3: begin
            i = $urandom_range(186, 65535);
            q[11] = i[7:0];
            q[12] = i[15:8];
         end
         default: ;
      endcase
      c = frame_crc(q, q.size());
      q.push_back(c[7:0]);
      q.push_back(c[15:8]);
      if (flaw == 4) begin
         i = $urandom_range(0, q.size() - 1);
         if (i >= 13) q[i] = q[i] ^ (8'd1 << $urandom_range(0, 7));
         else q[q.size()-1] = q[q.size()-1] ^ 8'h01;
      end
      return q;
   endfunction

   task automatic send_word(input sfp_pkg::cmd_type cmd, input logic [7:0] data);
      @(negedge clock);
      while ($urandom_range(0, 99) < sender_idle) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = cmd;
      req_tdata  = data;
      do @(posedge clock); while (!req_tready);
      bytes_fed++;
      parse_item(cmd, data);
   endtask

   task automatic send_frame(input byte_q_type q);
      foreach (q[i]) send_word(sfp_pkg::CMD_FEED, q[i]);
   endtask

   always @(negedge clock)
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle);

   always @(posedge clock) begin
      rsp_word_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind = rsp_tuser;
         got.last = rsp_tlast;
         got.word = rsp_tdata;
         words_checked++;
         if (pending_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected word: kind %0d last %0d data %h",
                        got.kind, got.last, got.word);
         end else begin
            want = pending_words.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("word %0d: expected kind %0d last %0d data %h, %s %0d %s %0d %s %h",
                           words_checked, want.kind, want.last, want.word,
                           "got kind", got.kind, "last", got.last, "data", got.word);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic add_row(input sfp_pkg::cmd_type cmd, input logic [7:0] data, input bit typed,
                          input int s, input int h, input int c, input int g);
      stim_row_type r;
      r.cmd = cmd;
      r.data = data;
      r.typed = typed;
      r.n_sync = s;
      r.n_hdr = h;
      r.n_crc = c;
      r.n_good = g;
      directed_rows.push_back(r);
   endtask

   initial begin
      byte_q_type q;
      int pick, n, cut;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = 8'd0;
      req_tuser = sfp_pkg::CMD_FEED;
      sync_drops = 0;
      header_drops = 0;
      crc_drops = 0;
      good_frames = 0;
      mismatches = 0;
      words_checked = 0;
      bytes_fed = 0;
      sender_idle = 16;
      recv_idle = 47;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      add_row(sfp_pkg::CMD_FEED, 8'h00, 1, 1, 0, 0, 0);
      add_row(sfp_pkg::CMD_FEED, 8'hAA, 1, 1, 0, 0, 0);
      add_row(sfp_pkg::CMD_FEED, 8'h55, 1, 1, 0, 0, 0);
      add_row(sfp_pkg::CMD_FEED, 8'h07, 1, 3, 1, 0, 0);
      add_row(sfp_pkg::CMD_FEED, 8'hFF, 1, 4, 1, 0, 0);
      add_row(sfp_pkg::CMD_CLEAR, 8'hFF, 1, 4, 1, 0, 0);
      add_row(sfp_pkg::CMD_FEED, 8'hAA, 1, 4, 1, 0, 0);
      add_row(sfp_pkg::CMD_CLEAR, 8'h00, 1, 4, 1, 0, 0);
      add_row(sfp_pkg::CMD_FEED, 8'h55, 1, 5, 1, 0, 0);
      q = build_frame(0, 0);
      foreach (q[i]) add_row(sfp_pkg::CMD_FEED, q[i], i == 14, 5, 1, 0, 1);

      foreach (directed_rows[i]) begin
         send_word(directed_rows[i].cmd, directed_rows[i].data);
         if (directed_rows[i].typed)
            pending_words[$].word[203:76] = {directed_rows[i].n_good, directed_rows[i].n_crc,
                                             directed_rows[i].n_hdr, directed_rows[i].n_sync};
      end

      for (int ph = 0; ph < 3; ph++) begin
         sender_idle = (ph == 0) ? 16 : (ph == 1) ? 47 : 0;
         recv_idle   = (ph == 0) ? 47 : (ph == 1) ? 16 : 0;
         n = bytes_fed;
         while (bytes_fed - n < 36) begin
            pick = $urandom_range(0, 9);
            if (pick <= 5) begin
               send_frame(build_frame($urandom_range(0, 12), 0));
            end else if (pick <= 7) begin
               send_frame(build_frame($urandom_range(0, 12), $urandom_range(1, 4)));
            end else if (pick == 8) begin
               repeat ($urandom_range(1, 6))
                  send_word(sfp_pkg::CMD_FEED, 8'($urandom_range(0, 255)));
            end else begin
               q = build_frame($urandom_range(0, 12), 0);
               cut = $urandom_range(0, q.size() - 1);
               for (int i = 0; i < cut; i++)
                  send_word(sfp_pkg::CMD_FEED, q[i]);
               send_word(sfp_pkg::CMD_CLEAR, 8'($urandom_range(0, 255)));
            end
         end
      end

      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (2000) @(posedge clock);

      $display("Fed %0d words; checked %0d result words", bytes_fed, words_checked);
      $display("Frames %0d, drops sync %0d header %0d crc %0d",
               good_frames, sync_drops, header_drops, crc_drops);
      if (mismatches == 0 && pending_words.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule

>>> sim.f
hw/rtl/sfp_pkg.sv
hw/rtl/sfp_ram.sv
hw/rtl/sync_frame_parser_crc16_core.sv
test/tb.sv
